// ===== sv/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Short forms for the concurrent checks of the segment link checker.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SSSL_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("segment link check failed");

// Next-cycle implication, disabled while reset is asserted.
`define SSSL_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("segment link check failed");

`endif

// ===== sv/sssl_pkg.sv =====
// ----------------------------------------------------------------------------
// sssl_pkg
// Shared constants, codes and types of the two-pin segment display link.
// ----------------------------------------------------------------------------
package sssl_pkg;

    // Waveform timing: steps per bit cycle and the step of each pin event.
    localparam int TICKS_PER_BIT = 8;
    localparam int TICK_W        = $clog2(TICKS_PER_BIT);
    localparam int AT_DATA       = TICKS_PER_BIT / 4;
    localparam int AT_ACK        = (TICKS_PER_BIT * 3) / 8;
    localparam int AT_HIGH       = TICKS_PER_BIT / 2;
    localparam int AT_EDGE       = (TICKS_PER_BIT * 3) / 4;

    // Bytes of a digit-write frame.
    localparam int FRAME_BYTES = 5;
    localparam int IDX_W       = $clog2(FRAME_BYTES);
    localparam int CNT_W       = $clog2(FRAME_BYTES + 1);

    // Bits of a shift-register word and the bit index of a byte's acknowledge clock.
    localparam int SHIFT_BITS = 16;
    localparam int BIT_W      = $clog2(SHIFT_BITS + 1);
    localparam int ACK_CLOCK  = 8;

    // Command bytes of the two-wire driver.
    localparam logic [7:0] CMD_ADDR_SET = 8'hC0;
    localparam logic [7:0] CMD_PAD      = 8'h00;
    localparam logic [7:0] CMD_DATA     = 8'h40;
    localparam logic [7:0] CMD_DISP_ON  = 8'h88;
    localparam logic [7:0] CMD_DISP_OFF = 8'h80;

    // Input op codes.
    localparam logic [2:0] OP_TICK  = 3'd0;
    localparam logic [2:0] OP_WRITE = 3'd1;
    localparam logic [2:0] OP_ON    = 3'd2;
    localparam logic [2:0] OP_OFF   = 3'd3;
    localparam logic [2:0] OP_DATA  = 3'd4;

    // Configuration register indexes and reset values.
    localparam int          CFG_IDX_W        = 2;
    localparam int          CFG_DATA_W       = 3;
    localparam logic [1:0]  REG_DRIVER_MODE  = 2'd0;
    localparam logic [1:0]  REG_BRIGHTNESS   = 2'd1;
    localparam logic [1:0]  REG_MAX_ATTEMPTS = 2'd2;
    localparam logic        RST_DRIVER_MODE  = 1'b0;
    localparam logic [2:0]  RST_BRIGHTNESS   = 3'd1;
    localparam logic [2:0]  RST_MAX_ATTEMPTS = 3'd3;

    // Depth of the queue between the front and the engine.
    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    typedef enum logic [2:0] {
        K_TICK,
        K_WRITE,
        K_ON,
        K_OFF,
        K_DATA,
        K_NONE
    } kind_t;

    typedef enum logic [4:0] {
        PH_IDLE  = 5'b00001,
        PH_START = 5'b00010,
        PH_BITS  = 5'b00100,
        PH_STOP  = 5'b01000,
        PH_SHIFT = 5'b10000
    } phase_t;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] seg0;
        logic [7:0] seg1;
        logic [7:0] seg2;
        logic       dat_in;
    } item_t;

    typedef struct packed {
        logic       driver_mode;
        logic [2:0] brightness;
        logic [2:0] max_attempts;
    } cfg_t;

    typedef struct packed {
        logic clk_out;
        logic dat_out;
        logic busy_res;
        logic done_res;
        logic fail;
        logic rejected;
    } result_t;

endpackage

// ===== sv/sssl_front.sv =====
// ----------------------------------------------------------------------------
// sssl_front
// Takes input items, decodes the op into a command kind and holds them in a
// short queue until the engine takes them.
// ----------------------------------------------------------------------------
module sssl_front (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [2:0]         s_op,
    input  logic [7:0]         s_seg0,
    input  logic [7:0]         s_seg1,
    input  logic [7:0]         s_seg2,
    input  logic               s_dat_in,
    output logic               q_valid,
    input  logic               q_pop,
    output sssl_pkg::item_t    q_item
);

    sssl_pkg::item_t                 q_mem_reg [sssl_pkg::Q_DEPTH];
    logic [sssl_pkg::Q_PTR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [sssl_pkg::Q_PTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [sssl_pkg::Q_CNT_W-1:0]    count_reg, count_next;
    sssl_pkg::item_t                 in_item;
    logic                            push;
    logic                            pop;

    always_comb begin
        case (s_op)
            sssl_pkg::OP_TICK:  in_item.kind = sssl_pkg::K_TICK;
            sssl_pkg::OP_WRITE: in_item.kind = sssl_pkg::K_WRITE;
            sssl_pkg::OP_ON:    in_item.kind = sssl_pkg::K_ON;
            sssl_pkg::OP_OFF:   in_item.kind = sssl_pkg::K_OFF;
            sssl_pkg::OP_DATA:  in_item.kind = sssl_pkg::K_DATA;
            default:            in_item.kind = sssl_pkg::K_NONE;
        endcase
        in_item.seg0   = s_seg0;
        in_item.seg1   = s_seg1;
        in_item.seg2   = s_seg2;
        in_item.dat_in = s_dat_in;
    end

    assign s_ready = (count_reg < sssl_pkg::Q_CNT_W'(sssl_pkg::Q_DEPTH));
    assign q_valid = (count_reg != '0);
    assign q_item  = q_mem_reg[rd_ptr_reg];
    assign push    = s_valid && s_ready;
    assign pop     = q_pop && q_valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == sssl_pkg::Q_PTR_W'(sssl_pkg::Q_DEPTH - 1)) ?
                          '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == sssl_pkg::Q_PTR_W'(sssl_pkg::Q_DEPTH - 1)) ?
                          '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            q_mem_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

// ===== sv/sssl_engine.sv =====
// ----------------------------------------------------------------------------
// sssl_engine
// Executes one queued item per cycle unless a result waits untaken: starts
// frames and shifts, advances the pin waveform on ticks, registers results.
// ----------------------------------------------------------------------------
module sssl_engine (
    input  logic               aclk,
    input  logic               aresetn,
    input  sssl_pkg::cfg_t     cfg,
    input  logic               q_valid,
    output logic               q_pop,
    input  sssl_pkg::item_t    q_item,
    output logic               m_valid,
    input  logic               m_ready,
    output sssl_pkg::result_t  m_result
);

    sssl_pkg::phase_t                phase_reg, phase_next;
    logic [sssl_pkg::TICK_W-1:0]     tick_reg, tick_next;
    logic [sssl_pkg::BIT_W-1:0]      bit_reg, bit_next;
    logic [sssl_pkg::CNT_W-1:0]      byte_reg, byte_next;
    logic [2:0]                      attempt_reg, attempt_next;
    logic [15:0]                     word_reg, word_next;
    logic [15:0]                     stored_reg, stored_next;
    logic [7:0]                      frame_reg [sssl_pkg::FRAME_BYTES];
    logic [7:0]                      frame_next [sssl_pkg::FRAME_BYTES];
    logic                            full_reg, full_next;
    logic                            bad_reg, bad_next;
    logic                            fail_reg, fail_next;
    logic                            clk_reg, clk_next;
    logic                            dat_reg, dat_next;
    logic                            m_valid_reg, m_valid_next;
    sssl_pkg::result_t               res_reg, res_next;
    logic                            step;
    logic                            last;
    logic                            done;
    logic                            rej;
    logic [2:0]                      limit;
    logic [7:0]                      cur_byte;
    logic [sssl_pkg::CNT_W-1:0]      frame_len;

    assign step    = q_valid && (!m_valid_reg || m_ready);
    assign q_pop   = step;
    assign last    = (tick_reg == sssl_pkg::TICK_W'(sssl_pkg::TICKS_PER_BIT - 1));
    assign limit   = (cfg.max_attempts == 3'd0) ? 3'd1 : cfg.max_attempts;
    assign cur_byte = (byte_reg < sssl_pkg::CNT_W'(sssl_pkg::FRAME_BYTES)) ?
                      frame_reg[byte_reg[sssl_pkg::IDX_W-1:0]] : frame_reg[0];
    assign frame_len = full_reg ? sssl_pkg::CNT_W'(sssl_pkg::FRAME_BYTES) :
                                  sssl_pkg::CNT_W'(1);

    always_comb begin
        phase_next   = phase_reg;
        tick_next    = tick_reg;
        bit_next     = bit_reg;
        byte_next    = byte_reg;
        attempt_next = attempt_reg;
        word_next    = word_reg;
        stored_next  = stored_reg;
        frame_next   = frame_reg;
        full_next    = full_reg;
        bad_next     = bad_reg;
        fail_next    = fail_reg;
        clk_next     = clk_reg;
        dat_next     = dat_reg;
        done         = 1'b0;
        rej          = 1'b0;

        if (step) begin
            if (q_item.kind == sssl_pkg::K_TICK) begin
                case (phase_reg)
                    sssl_pkg::PH_START, sssl_pkg::PH_STOP: begin
                        if (tick_reg == '0) clk_next = 1'b0;
                        if (tick_reg == sssl_pkg::TICK_W'(sssl_pkg::AT_HIGH)) clk_next = 1'b1;
                        if (tick_reg == sssl_pkg::TICK_W'(sssl_pkg::AT_EDGE)) begin
                            dat_next = (phase_reg == sssl_pkg::PH_STOP);
                        end
                        if (last) begin
                            if (phase_reg == sssl_pkg::PH_START) begin
                                phase_next = sssl_pkg::PH_BITS;
                                byte_next  = '0;
                                bit_next   = '0;
                            end else if (bad_reg && ({1'b0, attempt_reg} + 4'd1 <
                                                     {1'b0, limit})) begin
                                attempt_next = attempt_reg + 3'd1;
                                bad_next     = 1'b0;
                                phase_next   = sssl_pkg::PH_START;
                            end else begin
                                fail_next  = bad_reg;
                                phase_next = sssl_pkg::PH_IDLE;
                                done       = 1'b1;
                            end
                        end
                    end
                    sssl_pkg::PH_BITS: begin
                        if (tick_reg == '0) clk_next = 1'b0;
                        if (tick_reg == sssl_pkg::TICK_W'(sssl_pkg::AT_DATA)) begin
                            dat_next = (bit_reg < sssl_pkg::BIT_W'(sssl_pkg::ACK_CLOCK)) ?
                                       cur_byte[bit_reg[2:0]] : 1'b1;
                        end
                        if (tick_reg == sssl_pkg::TICK_W'(sssl_pkg::AT_ACK) &&
                            bit_reg == sssl_pkg::BIT_W'(sssl_pkg::ACK_CLOCK)) begin
                            bad_next = q_item.dat_in;
                            dat_next = 1'b0;
                        end
                        if (tick_reg == sssl_pkg::TICK_W'(sssl_pkg::AT_HIGH)) clk_next = 1'b1;
                        if (last) begin
                            bit_next = bit_reg + 1'b1;
                            if (bit_next > sssl_pkg::BIT_W'(sssl_pkg::ACK_CLOCK)) begin
                                bit_next  = '0;
                                byte_next = byte_reg + 1'b1;
                                if (bad_next || byte_next >= frame_len) begin
                                    phase_next = sssl_pkg::PH_STOP;
                                end
                            end
                        end
                    end
                    sssl_pkg::PH_SHIFT: begin
                        if (tick_reg == '0) clk_next = 1'b0;
                        if (tick_reg == sssl_pkg::TICK_W'(sssl_pkg::AT_DATA)) begin
                            dat_next = word_reg[15];
                        end
                        if (tick_reg == sssl_pkg::TICK_W'(sssl_pkg::AT_HIGH)) clk_next = 1'b1;
                        if (last) begin
                            word_next = {word_reg[14:0], 1'b0};
                            bit_next  = bit_reg + 1'b1;
                            if (bit_next >= sssl_pkg::BIT_W'(sssl_pkg::SHIFT_BITS)) begin
                                bit_next   = '0;
                                dat_next   = 1'b1;
                                fail_next  = 1'b0;
                                phase_next = sssl_pkg::PH_IDLE;
                                done       = 1'b1;
                            end
                        end
                    end
                    default: ;
                endcase
                if (phase_next != sssl_pkg::PH_IDLE && !done) begin
                    tick_next = last ? '0 : tick_reg + 1'b1;
                end else begin
                    tick_next = '0;
                end
            end else if (q_item.kind != sssl_pkg::K_NONE) begin
                if (phase_reg != sssl_pkg::PH_IDLE) begin
                    rej = 1'b1;
                end else if (!cfg.driver_mode) begin
                    // Two-wire frame: load the bytes, then a start condition.
                    fail_next = 1'b0;
                    case (q_item.kind)
                        sssl_pkg::K_WRITE: begin
                            for (int i = 0; i < sssl_pkg::FRAME_BYTES; i++) begin
                                case (i)
                                    0:       frame_next[i] = sssl_pkg::CMD_ADDR_SET;
                                    1:       frame_next[i] = q_item.seg0;
                                    2:       frame_next[i] = q_item.seg1;
                                    3:       frame_next[i] = q_item.seg2;
                                    default: frame_next[i] = sssl_pkg::CMD_PAD;
                                endcase
                            end
                            full_next = 1'b1;
                        end
                        sssl_pkg::K_ON: begin
                            frame_next[0] = sssl_pkg::CMD_DISP_ON + {5'd0, cfg.brightness};
                            full_next     = 1'b0;
                        end
                        sssl_pkg::K_OFF: begin
                            frame_next[0] = sssl_pkg::CMD_DISP_OFF;
                            full_next     = 1'b0;
                        end
                        default: begin
                            frame_next[0] = sssl_pkg::CMD_DATA;
                            full_next     = 1'b0;
                        end
                    endcase
                    attempt_next = '0;
                    byte_next    = '0;
                    bit_next     = '0;
                    tick_next    = '0;
                    bad_next     = 1'b0;
                    phase_next   = sssl_pkg::PH_START;
                end else if (q_item.kind != sssl_pkg::K_DATA) begin
                    // Shift-register word; the written pattern is kept for the display-on command.
                    fail_next = 1'b0;
                    case (q_item.kind)
                        sssl_pkg::K_WRITE: begin
                            stored_next = {q_item.seg0, q_item.seg1};
                            word_next   = {q_item.seg0, q_item.seg1};
                        end
                        sssl_pkg::K_ON: word_next = stored_reg;
                        default:        word_next = '0;
                    endcase
                    bit_next   = '0;
                    tick_next  = '0;
                    phase_next = sssl_pkg::PH_SHIFT;
                end
            end
        end

        res_next.clk_out  = clk_next;
        res_next.dat_out  = dat_next;
        res_next.busy_res = (phase_next != sssl_pkg::PH_IDLE);
        res_next.done_res = done;
        res_next.fail     = fail_next;
        res_next.rejected = rej;

        if (step) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= sssl_pkg::PH_IDLE;
            tick_reg    <= '0;
            bit_reg     <= '0;
            byte_reg    <= '0;
            attempt_reg <= '0;
            stored_reg  <= '0;
            bad_reg     <= 1'b0;
            fail_reg    <= 1'b0;
            clk_reg     <= 1'b1;
            dat_reg     <= 1'b1;
            m_valid_reg <= 1'b0;
        end else begin
            phase_reg   <= phase_next;
            tick_reg    <= tick_next;
            bit_reg     <= bit_next;
            byte_reg    <= byte_next;
            attempt_reg <= attempt_next;
            stored_reg  <= stored_next;
            bad_reg     <= bad_next;
            fail_reg    <= fail_next;
            clk_reg     <= clk_next;
            dat_reg     <= dat_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        word_reg  <= word_next;
        frame_reg <= frame_next;
        full_reg  <= full_next;
        if (step) begin
            res_reg <= res_next;
        end
    end

    assign m_valid  = m_valid_reg;
    assign m_result = res_reg;

endmodule

// ===== sv/seven_segment_serial_link.sv =====
// ----------------------------------------------------------------------------
// seven_segment_serial_link
// Result path: an accepted input item passes the front queue and the engine
//   step into the result register, held on the m_ ports until it is taken.
// Throughput: one item per clock while the result channel does not stall.
// Reset (aresetn low at a clock edge): queue and output empty, idle, pins
//   high, registers at their defaults; no clearing pass is needed.
// ----------------------------------------------------------------------------
module seven_segment_serial_link (
    input  logic                                aclk,
    input  logic                                aresetn,
    // Configuration write port.
    input  logic                                cfg_we,
    input  logic [sssl_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [sssl_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    // Input item channel.
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [2:0]                          s_op,
    input  logic [7:0]                          s_seg0,
    input  logic [7:0]                          s_seg1,
    input  logic [7:0]                          s_seg2,
    input  logic                                s_dat_in,
    // Result item channel.
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic                                m_clk_out,
    output logic                                m_dat_out,
    output logic                                m_busy_res,
    output logic                                m_done_res,
    output logic                                m_fail,
    output logic                                m_rejected
);

    // The block is split in two. The front decodes each item's op and keeps
    // it in a two-entry queue; the engine takes one item per clock whenever
    // its output register is free or being emptied, so the queue absorbs a
    // short downstream stall before the input is held up.

    sssl_pkg::cfg_t     cfg_reg, cfg_next;
    logic               q_valid;
    logic               q_pop;
    sssl_pkg::item_t    q_item;
    sssl_pkg::result_t  m_result;

    // Configuration registers. Writes to an index outside the list are
    // dropped. The engine reads them directly; the user must change them only
    // while the link is idle, as the block does not enforce this.
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            case (cfg_index)
                sssl_pkg::REG_DRIVER_MODE:  cfg_next.driver_mode  = cfg_wdata[0];
                sssl_pkg::REG_BRIGHTNESS:   cfg_next.brightness   = cfg_wdata[2:0];
                sssl_pkg::REG_MAX_ATTEMPTS: cfg_next.max_attempts = cfg_wdata[2:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.driver_mode  <= sssl_pkg::RST_DRIVER_MODE;
            cfg_reg.brightness   <= sssl_pkg::RST_BRIGHTNESS;
            cfg_reg.max_attempts <= sssl_pkg::RST_MAX_ATTEMPTS;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    sssl_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_op     (s_op),
        .s_seg0   (s_seg0),
        .s_seg1   (s_seg1),
        .s_seg2   (s_seg2),
        .s_dat_in (s_dat_in),
        .q_valid  (q_valid),
        .q_pop    (q_pop),
        .q_item   (q_item)
    );

    // The engine owns the waveform state: frame bytes, bit and tick counters,
    // the retry count and the kept shift pattern.
    sssl_engine u_engine (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .q_valid  (q_valid),
        .q_pop    (q_pop),
        .q_item   (q_item),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_result (m_result)
    );

    assign m_clk_out  = m_result.clk_out;
    assign m_dat_out  = m_result.dat_out;
    assign m_busy_res = m_result.busy_res;
    assign m_done_res = m_result.done_res;
    assign m_fail     = m_result.fail;
    assign m_rejected = m_result.rejected;

endmodule

// ===== sv/sssl_checker.sv =====
// ----------------------------------------------------------------------------
// sssl_checker
// Port-level checks of the segment link, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sssl_checker (
    input logic aclk,
    input logic aresetn,
    input logic m_valid,
    input logic m_ready,
    input logic m_clk_out,
    input logic m_dat_out,
    input logic m_busy_res,
    input logic m_done_res,
    input logic m_fail,
    input logic m_rejected
);

    // A finished command leaves the link idle.
    `SSSL_ASSERT_NOW(a_done_idle, aclk, aresetn, m_valid && m_done_res, !m_busy_res)

    // Only a command arriving during a transfer is turned away.
    `SSSL_ASSERT_NOW(a_rej_busy, aclk, aresetn, m_valid && m_rejected, m_busy_res)

    // Failure is reported only once the link has gone idle.
    `SSSL_ASSERT_NOW(a_fail_idle, aclk, aresetn, m_valid && m_fail, !m_busy_res)

    // A result not taken stays on the ports with its pin, busy and done fields unchanged.
    `SSSL_ASSERT_NEXT(a_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_clk_out) && $stable(m_dat_out) && $stable(m_busy_res) && $stable(m_done_res))

endmodule

bind seven_segment_serial_link sssl_checker u_sssl_checker (
    .aclk       (aclk),
    .aresetn    (aresetn),
    .m_valid    (m_valid),
    .m_ready    (m_ready),
    .m_clk_out  (m_clk_out),
    .m_dat_out  (m_dat_out),
    .m_busy_res (m_busy_res),
    .m_done_res (m_done_res),
    .m_fail     (m_fail),
    .m_rejected (m_rejected)
);

// ===== dv/seven_segment_serial_link_checker.sv =====
// ----------------------------------------------------------------------------
// seven_segment_serial_link_checker
// Watches both item channels and the register port of the segment link,
// predicts every result item and compares it, field by field, with the block.
// ----------------------------------------------------------------------------
module seven_segment_serial_link_checker (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_we,
    input  logic [sssl_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [sssl_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    input  logic                                s_valid,
    input  logic                                s_ready,
    input  logic [2:0]                          s_op,
    input  logic [7:0]                          s_seg0,
    input  logic [7:0]                          s_seg1,
    input  logic [7:0]                          s_seg2,
    input  logic                                s_dat_in,
    input  logic                                m_valid,
    input  logic                                m_ready,
    input  logic                                m_clk_out,
    input  logic                                m_dat_out,
    input  logic                                m_busy_res,
    input  logic                                m_done_res,
    input  logic                                m_fail,
    input  logic                                m_rejected,
    output int                                  mismatches,
    output int                                  outstanding,
    output int                                  results_checked,
    output int                                  commands_done,
    output int                                  commands_rejected
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int REPORT_LIMIT = 10;

    // Register copy.
    logic                               mode_q;
    logic [2:0]                         level_q;
    logic [2:0]                         tries_q;

    // Waveform state of the link.
    sssl_pkg::phase_t                   link_phase;
    logic [sssl_pkg::TICK_W-1:0]        step_q;
    logic [sssl_pkg::BIT_W-1:0]         bit_q;
    logic [sssl_pkg::IDX_W-1:0]         byte_q;
    logic [2:0]                         attempt_q;
    logic [15:0]                        shift_q;
    logic [7:0]                         frame_q [sssl_pkg::FRAME_BYTES];
    int                                 frame_len_q;
    logic [15:0]                        pattern_q;
    logic                               fail_q;
    logic                               nack_q;
    logic                               clk_q;
    logic                               dat_q;

    sssl_pkg::result_t                  expected_results [$];
    int                                 error_total;
    int                                 checked_total;
    int                                 done_total;
    int                                 reject_total;

    task automatic reset_link();
        mode_q      = sssl_pkg::RST_DRIVER_MODE;
        level_q     = sssl_pkg::RST_BRIGHTNESS;
        tries_q     = sssl_pkg::RST_MAX_ATTEMPTS;
        link_phase  = sssl_pkg::PH_IDLE;
        step_q      = '0;
        bit_q       = '0;
        byte_q      = '0;
        attempt_q   = '0;
        shift_q     = '0;
        for (int i = 0; i < sssl_pkg::FRAME_BYTES; i++) frame_q[i] = '0;
        frame_len_q = 0;
        pattern_q   = '0;
        fail_q      = 1'b0;
        nack_q      = 1'b0;
        clk_q       = 1'b1;
        dat_q       = 1'b1;
    endtask

    task automatic start_frame(input int len);
        frame_len_q = len;
        attempt_q   = '0;
        byte_q      = '0;
        bit_q       = '0;
        step_q      = '0;
        nack_q      = 1'b0;
        link_phase  = sssl_pkg::PH_START;
    endtask

    task automatic start_shift(input logic [15:0] word);
        shift_q    = word;
        bit_q      = '0;
        step_q     = '0;
        link_phase = sssl_pkg::PH_SHIFT;
    endtask

    // One step of the pin waveform; finished is raised when a command ends.
    task automatic advance_waveform(input logic din, output logic finished);
        int         t;
        logic       last;
        logic [7:0] cur;
        int         lim;
        t        = step_q;
        last     = (t == sssl_pkg::TICKS_PER_BIT - 1);
        finished = 1'b0;
        case (link_phase)
            sssl_pkg::PH_START, sssl_pkg::PH_STOP: begin
                if (t == 0) clk_q = 1'b0;
                if (t == sssl_pkg::AT_HIGH) clk_q = 1'b1;
                if (t == sssl_pkg::AT_EDGE) dat_q = (link_phase == sssl_pkg::PH_STOP);
                if (last) begin
                    if (link_phase == sssl_pkg::PH_START) begin
                        link_phase = sssl_pkg::PH_BITS;
                        byte_q     = '0;
                        bit_q      = '0;
                    end else begin
                        lim = (tries_q != 0) ? int'(tries_q) : 1;
                        if (nack_q && (int'(attempt_q) + 1 < lim)) begin
                            attempt_q  = attempt_q + 1'b1;
                            nack_q     = 1'b0;
                            link_phase = sssl_pkg::PH_START;
                        end else begin
                            fail_q     = nack_q;
                            link_phase = sssl_pkg::PH_IDLE;
                            finished   = 1'b1;
                        end
                    end
                end
            end
            sssl_pkg::PH_BITS: begin
                cur = frame_q[(byte_q < sssl_pkg::FRAME_BYTES) ? byte_q : 0];
                if (t == 0) clk_q = 1'b0;
                if (t == sssl_pkg::AT_DATA)
                    dat_q = (bit_q < sssl_pkg::ACK_CLOCK) ? cur[bit_q] : 1'b1;
                if (t == sssl_pkg::AT_ACK && bit_q == sssl_pkg::ACK_CLOCK) begin
                    nack_q = din;
                    dat_q  = 1'b0;
                end
                if (t == sssl_pkg::AT_HIGH) clk_q = 1'b1;
                if (last) begin
                    bit_q = bit_q + 1'b1;
                    if (bit_q >= sssl_pkg::ACK_CLOCK + 1) begin
                        bit_q  = '0;
                        byte_q = byte_q + 1'b1;
                        if (nack_q || int'(byte_q) >= frame_len_q)
                            link_phase = sssl_pkg::PH_STOP;
                    end
                end
            end
            sssl_pkg::PH_SHIFT: begin
                if (t == 0) clk_q = 1'b0;
                if (t == sssl_pkg::AT_DATA) dat_q = shift_q[15];
                if (t == sssl_pkg::AT_HIGH) clk_q = 1'b1;
                if (last) begin
                    shift_q = shift_q << 1;
                    bit_q   = bit_q + 1'b1;
                    if (bit_q >= sssl_pkg::SHIFT_BITS) begin
                        bit_q      = '0;
                        dat_q      = 1'b1;
                        fail_q     = 1'b0;
                        link_phase = sssl_pkg::PH_IDLE;
                        finished   = 1'b1;
                    end
                end
            end
            default: ;
        endcase
        if (link_phase != sssl_pkg::PH_IDLE && !finished) step_q = last ? '0 : step_q + 1'b1;
        else step_q = '0;
    endtask

    // Works out the result item that one accepted input item causes.
    task automatic predict_item(input logic [2:0] op, input logic [7:0] s0, s1, s2,
                                input logic din, output sssl_pkg::result_t r);
        logic finished;
        logic refused;
        finished = 1'b0;
        refused  = 1'b0;
        if (op == sssl_pkg::OP_TICK) begin
            advance_waveform(din, finished);
        end else if (op <= sssl_pkg::OP_DATA) begin
            if (link_phase != sssl_pkg::PH_IDLE) begin
                refused = 1'b1;
            end else if (mode_q == 1'b0) begin
                fail_q = 1'b0;
                if (op == sssl_pkg::OP_WRITE) begin
                    for (int i = 0; i < sssl_pkg::FRAME_BYTES; i++)
                        frame_q[i] = sssl_pkg::CMD_PAD;
                    frame_q[0] = sssl_pkg::CMD_ADDR_SET;
                    if (sssl_pkg::FRAME_BYTES > 1) frame_q[1 % sssl_pkg::FRAME_BYTES] = s0;
                    if (sssl_pkg::FRAME_BYTES > 2) frame_q[2 % sssl_pkg::FRAME_BYTES] = s1;
                    if (sssl_pkg::FRAME_BYTES > 3) frame_q[3 % sssl_pkg::FRAME_BYTES] = s2;
                    start_frame(sssl_pkg::FRAME_BYTES);
                end else begin
                    if (op == sssl_pkg::OP_ON) frame_q[0] = sssl_pkg::CMD_DISP_ON + level_q;
                    else if (op == sssl_pkg::OP_OFF) frame_q[0] = sssl_pkg::CMD_DISP_OFF;
                    else frame_q[0] = sssl_pkg::CMD_DATA;
                    start_frame(1);
                end
            end else if (op != sssl_pkg::OP_DATA) begin
                // Shift mode keeps the last pattern so that it can be restored.
                fail_q = 1'b0;
                if (op == sssl_pkg::OP_WRITE) begin
                    pattern_q = {s0, s1};
                    start_shift(pattern_q);
                end else begin
                    start_shift((op == sssl_pkg::OP_ON) ? pattern_q : 16'h0000);
                end
            end
        end
        r.clk_out  = clk_q;
        r.dat_out  = dat_q;
        r.busy_res = (link_phase != sssl_pkg::PH_IDLE);
        r.done_res = finished;
        r.fail     = fail_q;
        r.rejected = refused;
    endtask

    always @(posedge aclk) begin : monitor
        sssl_pkg::result_t got;
        sssl_pkg::result_t want;
        sssl_pkg::result_t fresh;
        logic              wrong;
        if (!aresetn) begin
            reset_link();
            expected_results.delete();
        end else begin
            // Results first, so that one arriving with nothing waiting is caught.
            if (m_valid && m_ready) begin
                got = '{clk_out: m_clk_out, dat_out: m_dat_out, busy_res: m_busy_res,
                        done_res: m_done_res, fail: m_fail, rejected: m_rejected};
                checked_total++;
                if (m_done_res === 1'b1) done_total++;
                if (m_rejected === 1'b1) reject_total++;
                if (expected_results.size() == 0) begin
                    error_total++;
                    if (error_total <= REPORT_LIMIT)
                        $display("checker: result %0d arrived with nothing expected",
                                 checked_total);
                end else begin
                    want  = expected_results.pop_front();
                    wrong = (got.clk_out  !== want.clk_out)  ||
                            (got.dat_out  !== want.dat_out)  ||
                            (got.busy_res !== want.busy_res) ||
                            (got.done_res !== want.done_res) ||
                            (got.fail     !== want.fail)     ||
                            (got.rejected !== want.rejected);
                    if (wrong) begin
                        error_total++;
                        if (error_total <= REPORT_LIMIT)
                            $display({"checker: result %0d clk/dat/busy/done/fail/rej ",
                                      "expected %b%b%b%b%b%b got %b%b%b%b%b%b"},
                                     checked_total, want.clk_out, want.dat_out,
                                     want.busy_res, want.done_res, want.fail,
                                     want.rejected, got.clk_out, got.dat_out,
                                     got.busy_res, got.done_res, got.fail, got.rejected);
                    end
                end
            end
            if (cfg_we) begin
                case (cfg_index)
                    sssl_pkg::REG_DRIVER_MODE:  mode_q  = cfg_wdata[0];
                    sssl_pkg::REG_BRIGHTNESS:   level_q = cfg_wdata[2:0];
                    sssl_pkg::REG_MAX_ATTEMPTS: tries_q = cfg_wdata[2:0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready) begin
                predict_item(s_op, s_seg0, s_seg1, s_seg2, s_dat_in, fresh);
                expected_results.push_back(fresh);
            end
        end
        mismatches        <= error_total;
        outstanding       <= expected_results.size();
        results_checked   <= checked_total;
        commands_done     <= done_total;
        commands_rejected <= reject_total;
    end

    initial begin
        error_total  = 0;
        checked_total = 0;
        done_total   = 0;
        reject_total = 0;
        reset_link();
    end

endmodule

// ===== dv/seven_segment_serial_link_tb.sv =====
// ----------------------------------------------------------------------------
// seven_segment_serial_link_tb
// Drives the two-pin segment display link with directed and random item
// sequences over several register settings and idling patterns; a checker
// beside the block predicts every result item and counts mismatches.
// ----------------------------------------------------------------------------
module seven_segment_serial_link_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_HALF       = 6;
    localparam int RESET_CYCLES   = 8;
    // Spare clocks waited after the last expected result has come back.
    localparam int DRAIN_PAD      = 3;
    // Longest deliberate stall of the receiver, and the watchdog several times over it.
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int SEGMENT_ITEMS  = 150;

    // Op codes that the block has no use for; they are ignored.
    localparam logic [2:0] OP_SPARE_LO  = 3'd5;
    localparam logic [2:0] OP_SPARE_MID = 3'd6;
    localparam logic [2:0] OP_SPARE_HI  = 3'd7;

    logic                               aclk      = 1'b0;
    logic                               aresetn   = 1'b0;
    logic                               cfg_we    = 1'b0;
    logic [sssl_pkg::CFG_IDX_W-1:0]     cfg_index = '0;
    logic [sssl_pkg::CFG_DATA_W-1:0]    cfg_wdata = '0;
    logic                               s_valid   = 1'b0;
    logic                               s_ready;
    logic [2:0]                         s_op      = sssl_pkg::OP_TICK;
    logic [7:0]                         s_seg0    = '0;
    logic [7:0]                         s_seg1    = '0;
    logic [7:0]                         s_seg2    = '0;
    logic                               s_dat_in  = 1'b0;
    logic                               m_valid;
    logic                               m_ready   = 1'b0;
    logic                               m_clk_out;
    logic                               m_dat_out;
    logic                               m_busy_res;
    logic                               m_done_res;
    logic                               m_fail;
    logic                               m_rejected;

    int mismatches;
    int outstanding;
    int results_checked;
    int commands_done;
    int commands_rejected;

    // Idling percentages of the two sides, changed between phases of the run.
    int send_idle_pct  = 0;
    int recv_idle_pct  = 0;
    // Set by the stimulus to ask the receiver for one long hold-off.
    int hold_request   = 0;
    int items_sent     = 0;
    int settings_used  = 0;
    int stall_cycles   = 0;

    always begin
        #(CLK_HALF) aclk = 1'b1;
        #(CLK_HALF) aclk = 1'b0;
    end

    seven_segment_serial_link i_dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_op       (s_op),
        .s_seg0     (s_seg0),
        .s_seg1     (s_seg1),
        .s_seg2     (s_seg2),
        .s_dat_in   (s_dat_in),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_clk_out  (m_clk_out),
        .m_dat_out  (m_dat_out),
        .m_busy_res (m_busy_res),
        .m_done_res (m_done_res),
        .m_fail     (m_fail),
        .m_rejected (m_rejected)
    );

    seven_segment_serial_link_checker i_checker (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_we            (cfg_we),
        .cfg_index         (cfg_index),
        .cfg_wdata         (cfg_wdata),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_op              (s_op),
        .s_seg0            (s_seg0),
        .s_seg1            (s_seg1),
        .s_seg2            (s_seg2),
        .s_dat_in          (s_dat_in),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_clk_out         (m_clk_out),
        .m_dat_out         (m_dat_out),
        .m_busy_res        (m_busy_res),
        .m_done_res        (m_done_res),
        .m_fail            (m_fail),
        .m_rejected        (m_rejected),
        .mismatches        (mismatches),
        .outstanding       (outstanding),
        .results_checked   (results_checked),
        .commands_done     (commands_done),
        .commands_rejected (commands_rejected)
    );

    // Offers one item and returns just after the edge at which it is accepted.
    // An idle gap, if one is drawn, lowers valid first; valid is never lowered
    // and raised in the same step, and it stays up until the item is taken.
    task automatic send_item(input logic [2:0] op, input logic [7:0] a, b, c,
                             input logic din);
        if ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(0, 99) < send_idle_pct);
        end
        s_valid  <= 1'b1;
        s_op     <= op;
        s_seg0   <= a;
        s_seg1   <= b;
        s_seg2   <= c;
        s_dat_in <= din;
        do @(posedge aclk); while (!s_ready);
        items_sent++;
    endtask

    // Stops offering items and waits until every expected result has come back.
    task automatic drain_link();
        s_valid <= 1'b0;
        do @(posedge aclk); while (outstanding != 0);
        repeat (DRAIN_PAD) @(posedge aclk);
    endtask

    // Writes all three registers on consecutive edges; only called when drained.
    task automatic write_registers(input logic mode, input logic [2:0] level,
                                   input logic [2:0] tries);
        cfg_we    <= 1'b1;
        cfg_index <= sssl_pkg::REG_DRIVER_MODE;
        cfg_wdata <= {2'b00, mode};
        @(posedge aclk);
        cfg_index <= sssl_pkg::REG_BRIGHTNESS;
        cfg_wdata <= level;
        @(posedge aclk);
        cfg_index <= sssl_pkg::REG_MAX_ATTEMPTS;
        cfg_wdata <= tries;
        @(posedge aclk);
        cfg_we <= 1'b0;
        settings_used++;
    endtask

    // Random traffic: mostly a command followed by a run of ticks, cut short
    // where the budget of the segment runs out, with the acknowledge level
    // drawn per run so that clean frames, retried frames and failed frames all
    // occur. A frame left unfinished carries on in the next segment. Stray
    // commands among the ticks are refused while busy, and spare op codes
    // are sprinkled in as noise.
    task automatic run_traffic(input int budget);
        int         done_here;
        int         roll;
        int         run_len;
        int         nack_pct;
        logic [2:0] op;
        done_here = 0;
        while (done_here < budget) begin
            roll = $urandom_range(0, 99);
            if (roll < 30) op = sssl_pkg::OP_WRITE;
            else if (roll < 50) op = sssl_pkg::OP_ON;
            else if (roll < 68) op = sssl_pkg::OP_OFF;
            else if (roll < 85) op = sssl_pkg::OP_DATA;
            else if (roll < 93) op = 3'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
            else op = sssl_pkg::OP_TICK;
            send_item(op, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                      8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
            roll = $urandom_range(0, 99);
            if (roll < 55) nack_pct = 0;
            else if (roll < 80) nack_pct = 4;
            else nack_pct = 70;
            run_len = ($urandom_range(0, 99) < 70) ? $urandom_range(80, 420)
                                                   : $urandom_range(1, 60);
            if (run_len > budget - done_here - 1) run_len = budget - done_here - 1;
            for (int k = 0; k < run_len; k++) begin
                if ($urandom_range(0, 99) < 3)
                    send_item(3'($urandom_range(sssl_pkg::OP_WRITE, OP_SPARE_HI)),
                              8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                              8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
                else
                    send_item(sssl_pkg::OP_TICK, 8'($urandom_range(0, 255)),
                              8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                              1'($urandom_range(0, 99) < nack_pct));
            end
            done_here += 1 + run_len;
        end
    endtask

    // Receiver: takes results with a random hold-off per cycle, and on request
    // holds off for a long stretch so that the block fills and stalls its input.
    initial begin : receiver
        int stretch;
        forever begin
            @(posedge aclk);
            if (hold_request > 0) begin
                stretch      = hold_request;
                hold_request = 0;
                m_ready     <= 1'b0;
                repeat (stretch) @(posedge aclk);
            end
            m_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // Watchdog: counts cycles in which nothing at all is accepted.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) || cfg_we)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    initial begin : stimulus
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part. Spare op codes while idle are ignored and not refused.
        send_item(OP_SPARE_LO, 8'hFF, 8'hFF, 8'hFF, 1'b1);
        send_item(OP_SPARE_MID, 8'h00, 8'h00, 8'h00, 1'b0);
        send_item(OP_SPARE_HI, 8'hA5, 8'h5A, 8'hC3, 1'b1);
        drain_link();

        // Shift-register mode: the data command has no meaning there and
        // gives no done pulse; a digit write then starts a 16-bit shift, and
        // commands that arrive during it are refused.
        write_registers(1'b1, 3'd7, 3'd7);
        send_item(sssl_pkg::OP_DATA, 8'hFF, 8'hFF, 8'hFF, 1'b1);
        send_item(sssl_pkg::OP_WRITE, 8'hFF, 8'h00, 8'hFF, 1'b0);
        send_item(sssl_pkg::OP_ON, 8'h00, 8'hFF, 8'h00, 1'b1);
        send_item(OP_SPARE_MID, 8'hFF, 8'hFF, 8'hFF, 1'b0);
        send_item(sssl_pkg::OP_TICK, 8'h00, 8'h00, 8'h00, 1'b1);
        send_item(sssl_pkg::OP_TICK, 8'hFF, 8'hFF, 8'hFF, 1'b0);
        send_item(sssl_pkg::OP_TICK, 8'h00, 8'h00, 8'h00, 1'b0);
        send_item(sssl_pkg::OP_TICK, 8'hFF, 8'hFF, 8'hFF, 1'b1);
        drain_link();

        // Registers change while the shift is still under way; it must keep
        // its mode. A zero attempt limit counts as a single attempt.
        write_registers(1'b0, 3'd0, 3'd0);
        send_item(sssl_pkg::OP_OFF, 8'hFF, 8'h00, 8'hFF, 1'b1);
        send_item(sssl_pkg::OP_WRITE, 8'h00, 8'hFF, 8'h00, 1'b0);
        send_item(sssl_pkg::OP_TICK, 8'h55, 8'hAA, 8'h55, 1'b0);
        send_item(sssl_pkg::OP_TICK, 8'hAA, 8'h55, 8'hAA, 1'b1);
        drain_link();

        // First idling pattern: the sender idles less than the receiver.
        send_idle_pct = 23;
        recv_idle_pct = 47;
        write_registers(1'b0, 3'd7, 3'd1);
        run_traffic(SEGMENT_ITEMS);
        drain_link();
        write_registers(1'b1, 3'd0, 3'd7);
        run_traffic(SEGMENT_ITEMS);
        drain_link();

        // Second pattern: the other way round.
        send_idle_pct = 47;
        recv_idle_pct = 23;
        write_registers(1'b0, 3'd0, 3'd0);
        run_traffic(SEGMENT_ITEMS);
        drain_link();
        write_registers(1'b0, 3'd3, 3'd7);
        run_traffic(SEGMENT_ITEMS);
        drain_link();

        // No idling on either side; the receiver first holds off for a long
        // stretch while the sender keeps offering items.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_registers(1'b1, 3'd5, 3'd2);
        hold_request = HOLD_CYCLES;
        run_traffic(SEGMENT_ITEMS);
        drain_link();
        write_registers(1'b0, 3'd7, 3'd3);
        run_traffic(SEGMENT_ITEMS);
        drain_link();

        $display("tb: %0d items sent, %0d results checked over %0d register settings",
                 items_sent, results_checked, settings_used);
        $display("tb: %0d commands finished, %0d commands refused while busy",
                 commands_done, commands_rejected);
        if (mismatches == 0 && outstanding == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
